FILE: rtl/qdec_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the quadrature decoder
// no dependencies

package qdec_pkg;

	// action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_SPEED  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// configuration register indexes and port widths
	localparam int unsigned    PADDR_W     = 3;
	localparam int unsigned    REG_IDX_W   = 1;
	localparam logic [REG_IDX_W-1:0] REG_REVERSE = 1'd0;

	// speed scaling and serial divider sizing
	localparam int unsigned    SCALE_W     = 10;
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 10'd1000;
	localparam int unsigned    DVD_W       = 41;
	localparam int unsigned    DIV_STEPS   = DVD_W;
	localparam int unsigned    CNT_W       = $clog2(DIV_STEPS);

	typedef struct packed {
		logic take;
		logic mul;
		logic div_step;
		logic finish;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic speed_go;
	} stat_t;

	// 4x decode table, index is {previous ab, current ab}
	function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
		logic signed [1:0] s;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
			default: s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/qdec_if.sv
`timescale 1ns / 1ps
// request and result channels of the quadrature decoder
// no dependencies

interface qdec_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic        pin_a;
	logic        pin_b;
	logic [15:0] interval_ms;

	modport source (output valid, action, pin_a, pin_b, interval_ms, input ready);
	modport sink (input valid, action, pin_a, pin_b, interval_ms, output ready);
endinterface

interface qdec_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_count;
	logic signed [15:0] speed_counts_per_s;
	logic signed [1:0]  step_taken;

	modport source (output valid, position_count, speed_counts_per_s, step_taken,
		input ready);
	modport sink (input valid, position_count, speed_counts_per_s, step_taken,
		output ready);
endinterface

FILE: rtl/quadrature_decoder_with_speed.sv
`timescale 1ns / 1ps
// quadrature decoder top level: sample, speed and clear requests, one result each
// sequencing: sample, clear and zero-interval speed requests go straight to the
// result register; a speed request first passes the multiply, the 41-step serial
// divider and saturation; flow: one request at a time, next request taken once
// the previous is loaded into the result register, held while the old one is unread
// reset: arst_n clears position, speed, decoder history and the direction register
// depends on qdec_pkg, qdec_if, qdec_ctrl, qdec_dp

module quadrature_decoder_with_speed (
	input  logic                         clk,
	input  logic                         arst_n,
	qdec_item_if.sink                    item,
	qdec_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qdec_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic                                reverse_q;
	logic [qdec_pkg::REG_IDX_W-1:0]      reg_idx;
	qdec_pkg::cmd_t                      cmd;
	qdec_pkg::stat_t                     stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[qdec_pkg::PADDR_W-1:2];
	assign prdata  = (reg_idx == qdec_pkg::REG_REVERSE) ? {31'd0, reverse_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_idx == qdec_pkg::REG_REVERSE) begin
			reverse_q <= pwdata[0];
		end
	end

	qdec_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	qdec_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.reverse            (reverse_q),
		.action             (item.action),
		.pin_a              (item.pin_a),
		.pin_b              (item.pin_b),
		.interval_ms        (item.interval_ms),
		.position_count     (result.position_count),
		.speed_counts_per_s (result.speed_counts_per_s),
		.step_taken         (result.step_taken)
	);

endmodule

FILE: rtl/qdec_dp.sv
`timescale 1ns / 1ps
// datapath: position counter, speed multiply, serial divider, result register
// depends on qdec_pkg

module qdec_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qdec_pkg::cmd_t       cmd,
	output qdec_pkg::stat_t      stat,
	input  logic                 reverse,
	input  logic [1:0]           action,
	input  logic                 pin_a,
	input  logic                 pin_b,
	input  logic [15:0]          interval_ms,
	output logic signed [31:0]   position_count,
	output logic signed [15:0]   speed_counts_per_s,
	output logic signed [1:0]    step_taken
);

	logic [1:0]                  prev_ab_q;
	logic                        primed_q;
	logic [31:0]                 pos_q;
	logic [31:0]                 last_pos_q;
	logic signed [15:0]          speed_q;
	logic signed [1:0]           step_q;
	logic [31:0]                 delta_q;
	logic [15:0]                 divisor_q;
	logic                        neg_q;
	logic [qdec_pkg::DVD_W-1:0]  dvd_q;
	logic [qdec_pkg::DVD_W-1:0]  quo_q;
	logic [15:0]                 rem_q;

	logic [1:0]                  now_ab;
	logic signed [1:0]           step_raw;
	logic signed [1:0]           step_dir;
	logic [31:0]                 mag;
	logic [qdec_pkg::DVD_W:0]    prod;
	logic [16:0]                 rem_sh;
	logic                        fits;
	logic [16:0]                 rem_sub;
	logic [15:0]                 speed_sat;

	assign now_ab   = {pin_a, pin_b};
	assign step_raw = qdec_pkg::step_lut({prev_ab_q, now_ab});
	assign step_dir = reverse ? -step_raw : step_raw;

	assign stat.speed_go = (action == qdec_pkg::ACT_SPEED) && (interval_ms != 16'd0);

	// magnitude of the position change, 1000 folded in as a constant multiply
	assign mag  = delta_q[31] ? (~delta_q + 32'd1) : delta_q;
	assign prod = {{(qdec_pkg::DVD_W - 31){1'b0}}, mag}
		* {{(qdec_pkg::DVD_W + 1 - qdec_pkg::SCALE_W){1'b0}}, qdec_pkg::SPEED_SCALE};

	// one restoring division step per cycle
	assign rem_sh  = {rem_q, dvd_q[qdec_pkg::DVD_W-1]};
	assign fits    = rem_sh >= {1'b0, divisor_q};
	assign rem_sub = rem_sh - {1'b0, divisor_q};

	// quotient truncates toward zero, then clamps to int16
	always_comb begin
		if (neg_q) begin
			if (quo_q > qdec_pkg::DVD_W'(32768)) begin
				speed_sat = 16'h8000;
			end else begin
				speed_sat = ~quo_q[15:0] + 16'd1;
			end
		end else begin
			if (quo_q > qdec_pkg::DVD_W'(32767)) begin
				speed_sat = 16'h7fff;
			end else begin
				speed_sat = quo_q[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q  <= 2'd0;
			primed_q   <= 1'b0;
			pos_q      <= 32'd0;
			last_pos_q <= 32'd0;
			speed_q    <= 16'sd0;
		end else begin
			if (cmd.take) begin
				case (action)
					qdec_pkg::ACT_SAMPLE: begin
						if (primed_q) begin
							pos_q <= pos_q + {{30{step_dir[1]}}, step_dir};
						end
						primed_q  <= 1'b1;
						prev_ab_q <= now_ab;
					end
					qdec_pkg::ACT_CLEAR: begin
						pos_q      <= 32'd0;
						last_pos_q <= 32'd0;
						speed_q    <= 16'sd0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.finish) begin
				speed_q    <= speed_sat;
				last_pos_q <= pos_q;
			end
		end
	end

	// working registers of the speed path and the result register
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			step_q    <= (action == qdec_pkg::ACT_SAMPLE && primed_q) ? step_dir : 2'sd0;
			delta_q   <= pos_q - last_pos_q;
			divisor_q <= interval_ms;
		end
		if (cmd.mul) begin
			neg_q <= delta_q[31];
			dvd_q <= prod[qdec_pkg::DVD_W-1:0];
			quo_q <= '0;
			rem_q <= 16'd0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[qdec_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[qdec_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? rem_sub[15:0] : rem_sh[15:0];
		end
		if (cmd.load_out) begin
			position_count     <= pos_q;
			speed_counts_per_s <= speed_q;
			step_taken         <= step_q;
		end
	end

endmodule

FILE: rtl/qdec_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences one request at a time and owns the result valid flag
// depends on qdec_pkg

module qdec_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  qdec_pkg::stat_t stat,
	output qdec_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SAT,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [qdec_pkg::CNT_W-1:0] cnt_q;
	logic                      out_free;

	assign item_ready = (state_q == ST_IDLE);
	assign out_free   = !result_valid || result_ready;

	always_comb begin
		cmd          = '0;
		cmd.take     = (state_q == ST_IDLE) && item_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_SAT);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= stat.speed_go ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == qdec_pkg::CNT_W'(qdec_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// wait here only while the previous result is still unread
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
